/* hdl/crs_pkg.sv */
// Shared types and constants for the Chinese remainder solver.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package crs_pkg;

   localparam int unsigned MAX_PAIRS_DEF    = 8;
   localparam int unsigned MODULUS_BITS_DEF = 32;
   localparam int unsigned FIELD_W          = 32;
   localparam int unsigned WORD_W           = 64;
   localparam int unsigned STATUS_W         = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_COMMON   = 2'd2
   } status_type;

   typedef enum logic {
      ARITH_MUL,
      ARITH_DIV
   } arith_op_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_INIT, CMD_FAIL_COP, CMD_PRD_GO, CMD_PRD_WT,
      CMD_GCD_INIT, CMD_LD_X, CMD_LD_Y, CMD_DIV_AB, CMD_GCD_WT, CMD_GCD_NEXT,
      CMD_SUM_INIT, CMD_SUM_LD, CMD_C_GO, CMD_C_WT, CMD_CM_GO, CMD_CM_WT,
      CMD_INV_DWT, CMD_INV_MGO, CMD_INV_MWT, CMD_INV_END, CMD_R_GO, CMD_R_WT,
      CMD_T_MGO, CMD_T_MWT, CMD_T_DGO, CMD_T_DWT, CMD_TC_GO, CMD_TC_WT,
      CMD_CLEAR
   } cmd_type;

   typedef struct packed {
      cmd_type op;
      logic    rd_j;
   } dp_cmd_type;

   typedef struct packed {
      logic arith_done;
      logic zero_seen;
      logic overflow;
      logic single;
      logic i_last;
      logic j_last;
      logic i_penult;
      logic ea_one;
      logic inv_stop;
      logic eb_zero;
   } dp_stat_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_CHK, ST_ZERO, ST_PRD_RD, ST_PRD_GO, ST_PRD_WT,
      ST_GCD_INIT, ST_GCD_RDI, ST_GCD_LDI, ST_GCD_LDJ, ST_GCD_TST, ST_GCD_GO,
      ST_GCD_WT, ST_GCD_END, ST_SUM_INIT, ST_SUM_RD, ST_SUM_LD, ST_C_GO,
      ST_C_WT, ST_CM_GO, ST_CM_WT, ST_INV_TST, ST_INV_DGO, ST_INV_DWT,
      ST_INV_MGO, ST_INV_MWT, ST_INV_END, ST_R_GO, ST_R_WT, ST_T_MGO,
      ST_T_MWT, ST_T_DGO, ST_T_DWT, ST_TC_GO, ST_TC_WT, ST_OUT
   } state_type;

endpackage

`default_nettype wire

/* hdl/crs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on crs_pkg for default sizes only.
`default_nettype none

module crs_ram #(
   parameter int unsigned WIDTH  = 2 * crs_pkg::MODULUS_BITS_DEF,
   parameter int unsigned DEPTH  = crs_pkg::MAX_PAIRS_DEF,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/crs_arith.sv */
// Shared iterative unit: restoring 64-bit divider (one bit per cycle) and
// shift-add multiplier (one multiplier bit per cycle). Depends on crs_pkg.
`default_nettype none

module crs_arith #(
   parameter int unsigned MODULUS_BITS = crs_pkg::MODULUS_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  crs_pkg::arith_op_type                     op,
   input  logic [crs_pkg::WORD_W-1:0]                opa,
   input  logic [crs_pkg::WORD_W-1:0]                opb,
   output logic                                      done,
   output logic [crs_pkg::WORD_W-1:0]                quo,
   output logic [crs_pkg::WORD_W-1:0]                rem,
   output logic [crs_pkg::WORD_W+MODULUS_BITS-1:0]   prod
);
   import crs_pkg::*;

   localparam int unsigned MB    = MODULUS_BITS;
   localparam int unsigned PW    = WORD_W + MB;
   localparam int unsigned CNT_W = $clog2(WORD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   arith_op_type     op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0] num_ff, num_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [WORD_W-1:0] mpa_ff, mpa_in;
   logic [MB-1:0]     mpb_ff, mpb_in;

   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;
   logic              ge;
   logic [PW-1:0]     addend;

   always_comb begin
      trial  = {rem_ff, num_ff[WORD_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = (trial >= {1'b0, den_ff});
      addend = mpb_ff[MB-1] ? {{MB{1'b0}}, mpa_ff} : '0;

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      mpa_in  = mpa_ff;
      mpb_in  = mpb_ff;

      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         cnt_in  = (op == ARITH_DIV) ? CNT_W'(WORD_W) : CNT_W'(MB);
         num_in  = opa;
         den_in  = opb;
         rem_in  = '0;
         acc_in  = '0;
         mpa_in  = opa;
         mpb_in  = opb[MB-1:0];
      end else if (busy_ff) begin
         // advance one quotient bit or one multiplier bit
         if (op_ff == ARITH_DIV) begin
            rem_in = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            num_in = {num_ff[WORD_W-2:0], ge};
         end else begin
            acc_in = {acc_ff[PW-2:0], 1'b0} + addend;
            mpb_in = {mpb_ff[MB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      mpa_ff <= mpa_in;
      mpb_ff <= mpb_in;
   end

   assign done = done_ff;
   assign quo  = num_ff;
   assign rem  = rem_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

/* hdl/crs_dp.sv */
// Datapath of the solver: pair store, working registers and the shared
// arithmetic unit. Depends on crs_pkg, crs_ram and crs_arith.
`default_nettype none

module crs_dp #(
   parameter int unsigned MAX_PAIRS    = crs_pkg::MAX_PAIRS_DEF,
   parameter int unsigned MODULUS_BITS = crs_pkg::MODULUS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  crs_pkg::dp_cmd_type           cmd,
   output crs_pkg::dp_stat_type          stat,
   input  logic [crs_pkg::FIELD_W-1:0]   req_modulus,
   input  logic [crs_pkg::FIELD_W-1:0]   req_remainder,
   output logic [crs_pkg::WORD_W-1:0]    rsp_solution,
   output logic [crs_pkg::STATUS_W-1:0]  rsp_status
);
   import crs_pkg::*;

   localparam int unsigned MB    = MODULUS_BITS;
   localparam int unsigned PW    = WORD_W + MB;
   localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);
   localparam int unsigned EW    = CNT_W + 1;
   localparam int unsigned IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int unsigned RAM_W = 2 * MB;
   localparam int unsigned PAD_W = WORD_W - MB;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              zero_ff, zero_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [WORD_W-1:0] prd_ff, prd_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [MB-1:0]     m_ff, m_in;
   logic [MB-1:0]     r_ff, r_in;
   logic [WORD_W-1:0] c_ff, c_in;
   logic [WORD_W-1:0] ea_ff, ea_in;
   logic [MB-1:0]     eb_ff, eb_in;
   logic [MB-1:0]     q_ff, q_in;
   logic [MB-1:0]     t_ff, t_in;
   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [WORD_W-1:0] cur_ff, cur_in;
   status_type        status_ff, status_in;

   logic              we;
   logic [RAM_W-1:0]  rd_data;
   logic [MB-1:0]     rd_mod;
   logic [MB-1:0]     rd_rem;
   logic [MB-1:0]     in_mod;
   logic [MB-1:0]     in_rem;
   logic [IDX_W-1:0]  rd_addr;

   logic              ar_start;
   arith_op_type      ar_op;
   logic [WORD_W-1:0] ar_a, ar_b;
   logic              ar_done;
   logic [WORD_W-1:0] ar_quo, ar_rem;
   logic [PW-1:0]     ar_prod;

   logic [EW-1:0]     i_nx1, i_nx2, j_nx1;
   logic [WORD_W:0]   acc_sum;
   logic [WORD_W-1:0] inv_val;

   assign in_mod  = req_modulus[MB-1:0];
   assign in_rem  = req_remainder[MB-1:0];
   assign rd_mod  = rd_data[MB-1:0];
   assign rd_rem  = rd_data[RAM_W-1:MB];
   assign rd_addr = cmd.rd_j ? j_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];
   assign we      = (cmd.op == CMD_LOAD) && (cnt_ff < CNT_W'(MAX_PAIRS));

   crs_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_PAIRS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data ({in_rem, in_mod}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   crs_arith #(
      .MODULUS_BITS (MB)
   ) u_arith (
      .clock (clock),
      .reset (reset),
      .start (ar_start),
      .op    (ar_op),
      .opa   (ar_a),
      .opb   (ar_b),
      .done  (ar_done),
      .quo   (ar_quo),
      .rem   (ar_rem),
      .prod  (ar_prod)
   );

   assign i_nx1   = EW'(i_ff) + EW'(1);
   assign i_nx2   = EW'(i_ff) + EW'(2);
   assign j_nx1   = EW'(j_ff) + EW'(1);
   assign acc_sum = {1'b0, sum_ff} + {1'b0, ar_prod[WORD_W-1:0]};
   assign inv_val = (m_ff == MB'(1)) ? '0 :
                    (cur_ff[WORD_W-1] ? cur_ff + {{PAD_W{1'b0}}, m_ff} : cur_ff);

   // operand selection for the shared unit
   always_comb begin
      ar_start = 1'b0;
      ar_op    = ARITH_DIV;
      ar_a     = '0;
      ar_b     = '0;
      unique case (cmd.op)
         CMD_PRD_GO: begin
            ar_start = 1'b1;
            ar_op    = ARITH_MUL;
            ar_a     = prd_ff;
            ar_b     = {{PAD_W{1'b0}}, rd_mod};
         end
         CMD_DIV_AB: begin
            ar_start = 1'b1;
            ar_a     = ea_ff;
            ar_b     = {{PAD_W{1'b0}}, eb_ff};
         end
         CMD_C_GO: begin
            ar_start = 1'b1;
            ar_a     = prd_ff;
            ar_b     = {{PAD_W{1'b0}}, m_ff};
         end
         CMD_CM_GO: begin
            ar_start = 1'b1;
            ar_a     = c_ff;
            ar_b     = {{PAD_W{1'b0}}, m_ff};
         end
         CMD_INV_MGO: begin
            ar_start = 1'b1;
            ar_op    = ARITH_MUL;
            ar_a     = prev_ff;
            ar_b     = {{PAD_W{1'b0}}, q_ff};
         end
         CMD_R_GO: begin
            ar_start = 1'b1;
            ar_a     = {{PAD_W{1'b0}}, r_ff};
            ar_b     = {{PAD_W{1'b0}}, m_ff};
         end
         CMD_T_MGO: begin
            ar_start = 1'b1;
            ar_op    = ARITH_MUL;
            ar_a     = ea_ff;
            ar_b     = {{PAD_W{1'b0}}, t_ff};
         end
         CMD_T_DGO: begin
            ar_start = 1'b1;
            ar_a     = ea_ff;
            ar_b     = {{PAD_W{1'b0}}, m_ff};
         end
         CMD_TC_GO: begin
            ar_start = 1'b1;
            ar_op    = ARITH_MUL;
            ar_a     = c_ff;
            ar_b     = {{PAD_W{1'b0}}, t_ff};
         end
         default: begin
            ar_start = 1'b0;
         end
      endcase
   end

   // register updates
   always_comb begin
      cnt_in    = cnt_ff;
      zero_in   = zero_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      prd_in    = prd_ff;
      sum_in    = sum_ff;
      m_in      = m_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      ea_in     = ea_ff;
      eb_in     = eb_ff;
      q_in      = q_ff;
      t_in      = t_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      unique case (cmd.op)
         CMD_LOAD: begin
            if (we) begin
               cnt_in = CNT_W'(i_nx1 - i_nx1) + cnt_ff + CNT_W'(1);
               if (in_mod == '0) begin
                  zero_in = 1'b1;
               end
            end
         end
         CMD_INIT: begin
            i_in      = '0;
            prd_in    = WORD_W'(1);
            status_in = STATUS_OK;
         end
         CMD_FAIL_COP: begin
            status_in = STATUS_COMMON;
         end
         CMD_PRD_WT: begin
            if (ar_done) begin
               if (stat.overflow) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  prd_in = ar_prod[WORD_W-1:0];
                  i_in   = i_nx1[CNT_W-1:0];
               end
            end
         end
         CMD_GCD_INIT: begin
            i_in = '0;
            j_in = CNT_W'(1);
         end
         CMD_LD_X: begin
            ea_in = {{PAD_W{1'b0}}, rd_mod};
         end
         CMD_LD_Y: begin
            eb_in = rd_mod;
         end
         CMD_GCD_WT: begin
            if (ar_done) begin
               ea_in = {{PAD_W{1'b0}}, eb_ff};
               eb_in = ar_rem[MB-1:0];
            end
         end
         CMD_GCD_NEXT: begin
            priority if (ea_ff != WORD_W'(1)) begin
               status_in = STATUS_COMMON;
            end else if (stat.j_last) begin
               i_in = i_nx1[CNT_W-1:0];
               j_in = i_nx2[CNT_W-1:0];
            end else begin
               j_in = j_nx1[CNT_W-1:0];
            end
         end
         CMD_SUM_INIT: begin
            i_in   = '0;
            sum_in = '0;
         end
         CMD_SUM_LD: begin
            m_in = rd_mod;
            r_in = rd_rem;
         end
         CMD_C_WT: begin
            if (ar_done) begin
               c_in = ar_quo;
            end
         end
         CMD_CM_WT: begin
            if (ar_done) begin
               ea_in   = ar_rem;
               eb_in   = m_ff;
               prev_in = '0;
               cur_in  = WORD_W'(1);
            end
         end
         CMD_INV_DWT: begin
            if (ar_done) begin
               q_in  = ar_quo[MB-1:0];
               ea_in = {{PAD_W{1'b0}}, eb_ff};
               eb_in = ar_rem[MB-1:0];
            end
         end
         CMD_INV_MWT: begin
            if (ar_done) begin
               prev_in = cur_ff - ar_prod[WORD_W-1:0];
               cur_in  = prev_ff;
            end
         end
         CMD_INV_END: begin
            t_in = inv_val[MB-1:0];
         end
         CMD_R_WT: begin
            if (ar_done) begin
               ea_in = ar_rem;
            end
         end
         CMD_T_MWT: begin
            if (ar_done) begin
               ea_in = ar_prod[WORD_W-1:0];
            end
         end
         CMD_T_DWT: begin
            if (ar_done) begin
               t_in = ar_rem[MB-1:0];
            end
         end
         CMD_TC_WT: begin
            if (ar_done) begin
               // fold the term in modulo the product
               if (acc_sum[WORD_W] || (acc_sum[WORD_W-1:0] >= prd_ff)) begin
                  sum_in = acc_sum[WORD_W-1:0] - prd_ff;
               end else begin
                  sum_in = acc_sum[WORD_W-1:0];
               end
               i_in = i_nx1[CNT_W-1:0];
            end
         end
         CMD_CLEAR: begin
            cnt_in  = '0;
            zero_in = 1'b0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         zero_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         zero_ff <= zero_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      prd_ff    <= prd_in;
      sum_ff    <= sum_in;
      m_ff      <= m_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      ea_ff     <= ea_in;
      eb_ff     <= eb_in;
      q_ff      <= q_in;
      t_ff      <= t_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
   end

   always_comb begin
      stat.arith_done = ar_done;
      stat.zero_seen  = zero_ff;
      stat.overflow   = |ar_prod[PW-1:WORD_W];
      stat.single     = (cnt_ff == CNT_W'(1));
      stat.i_last     = (i_nx1 == EW'(cnt_ff));
      stat.j_last     = (j_nx1 == EW'(cnt_ff));
      stat.i_penult   = (i_nx2 == EW'(cnt_ff));
      stat.ea_one     = (ea_ff == WORD_W'(1));
      stat.eb_zero    = (eb_ff == '0);
      stat.inv_stop   = (m_ff == MB'(1)) || (ea_ff <= WORD_W'(1)) || (eb_ff == '0);
   end

   assign rsp_solution = (status_ff == STATUS_OK) ? sum_ff : '0;
   assign rsp_status   = status_ff;

endmodule

`default_nettype wire

/* hdl/crs_ctrl.sv */
// Controller of the solver: sequences load, product, coprime check and
// accumulation through command and status structs. Depends on crs_pkg.
`default_nettype none

module crs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   input  logic                  rsp_stall,
   input  crs_pkg::dp_stat_type  stat,
   output crs_pkg::dp_cmd_type   cmd,
   output logic                  req_stall,
   output logic                  rsp_valid
);
   import crs_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid && req_last) state_in = ST_CHK;
         ST_CHK:      state_in = stat.zero_seen ? ST_ZERO : ST_PRD_RD;
         ST_ZERO:     state_in = ST_OUT;
         ST_PRD_RD:   state_in = ST_PRD_GO;
         ST_PRD_GO:   state_in = ST_PRD_WT;
         ST_PRD_WT: begin
            if (stat.arith_done) begin
               priority if (stat.overflow) state_in = ST_OUT;
               else if (stat.i_last)       state_in = ST_GCD_INIT;
               else                        state_in = ST_PRD_RD;
            end
         end
         ST_GCD_INIT: state_in = stat.single ? ST_SUM_INIT : ST_GCD_RDI;
         ST_GCD_RDI:  state_in = ST_GCD_LDI;
         ST_GCD_LDI:  state_in = ST_GCD_LDJ;
         ST_GCD_LDJ:  state_in = ST_GCD_TST;
         ST_GCD_TST:  state_in = stat.eb_zero ? ST_GCD_END : ST_GCD_GO;
         ST_GCD_GO:   state_in = ST_GCD_WT;
         ST_GCD_WT:   if (stat.arith_done) state_in = ST_GCD_TST;
         ST_GCD_END: begin
            priority if (!stat.ea_one)              state_in = ST_OUT;
            else if (stat.i_penult && stat.j_last)  state_in = ST_SUM_INIT;
            else                                    state_in = ST_GCD_RDI;
         end
         ST_SUM_INIT: state_in = ST_SUM_RD;
         ST_SUM_RD:   state_in = ST_SUM_LD;
         ST_SUM_LD:   state_in = ST_C_GO;
         ST_C_GO:     state_in = ST_C_WT;
         ST_C_WT:     if (stat.arith_done) state_in = ST_CM_GO;
         ST_CM_GO:    state_in = ST_CM_WT;
         ST_CM_WT:    if (stat.arith_done) state_in = ST_INV_TST;
         ST_INV_TST:  state_in = stat.inv_stop ? ST_INV_END : ST_INV_DGO;
         ST_INV_DGO:  state_in = ST_INV_DWT;
         ST_INV_DWT:  if (stat.arith_done) state_in = ST_INV_MGO;
         ST_INV_MGO:  state_in = ST_INV_MWT;
         ST_INV_MWT:  if (stat.arith_done) state_in = ST_INV_TST;
         ST_INV_END:  state_in = ST_R_GO;
         ST_R_GO:     state_in = ST_R_WT;
         ST_R_WT:     if (stat.arith_done) state_in = ST_T_MGO;
         ST_T_MGO:    state_in = ST_T_MWT;
         ST_T_MWT:    if (stat.arith_done) state_in = ST_T_DGO;
         ST_T_DGO:    state_in = ST_T_DWT;
         ST_T_DWT:    if (stat.arith_done) state_in = ST_TC_GO;
         ST_TC_GO:    state_in = ST_TC_WT;
         ST_TC_WT: begin
            if (stat.arith_done) begin
               state_in = stat.i_last ? ST_OUT : ST_SUM_RD;
            end
         end
         ST_OUT:      if (!rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = CMD_NONE;
      cmd.rd_j  = 1'b0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = CMD_LOAD;
         end
         ST_CHK:      cmd.op = CMD_INIT;
         ST_ZERO:     cmd.op = CMD_FAIL_COP;
         ST_PRD_GO:   cmd.op = CMD_PRD_GO;
         ST_PRD_WT:   cmd.op = CMD_PRD_WT;
         ST_GCD_INIT: cmd.op = CMD_GCD_INIT;
         ST_GCD_LDI: begin
            cmd.op   = CMD_LD_X;
            cmd.rd_j = 1'b1;
         end
         ST_GCD_LDJ:  cmd.op = CMD_LD_Y;
         ST_GCD_GO:   cmd.op = CMD_DIV_AB;
         ST_GCD_WT:   cmd.op = CMD_GCD_WT;
         ST_GCD_END:  cmd.op = CMD_GCD_NEXT;
         ST_SUM_INIT: cmd.op = CMD_SUM_INIT;
         ST_SUM_LD:   cmd.op = CMD_SUM_LD;
         ST_C_GO:     cmd.op = CMD_C_GO;
         ST_C_WT:     cmd.op = CMD_C_WT;
         ST_CM_GO:    cmd.op = CMD_CM_GO;
         ST_CM_WT:    cmd.op = CMD_CM_WT;
         ST_INV_DGO:  cmd.op = CMD_DIV_AB;
         ST_INV_DWT:  cmd.op = CMD_INV_DWT;
         ST_INV_MGO:  cmd.op = CMD_INV_MGO;
         ST_INV_MWT:  cmd.op = CMD_INV_MWT;
         ST_INV_END:  cmd.op = CMD_INV_END;
         ST_R_GO:     cmd.op = CMD_R_GO;
         ST_R_WT:     cmd.op = CMD_R_WT;
         ST_T_MGO:    cmd.op = CMD_T_MGO;
         ST_T_MWT:    cmd.op = CMD_T_MWT;
         ST_T_DGO:    cmd.op = CMD_T_DGO;
         ST_T_DWT:    cmd.op = CMD_T_DWT;
         ST_TC_GO:    cmd.op = CMD_TC_GO;
         ST_TC_WT:    cmd.op = CMD_TC_WT;
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) cmd.op = CMD_CLEAR;
         end
         default:     cmd.op = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/chinese_remainder_solver.sv */
// Top level of the Chinese remainder solver: controller plus datapath.
// Depends on crs_pkg, crs_ctrl and crs_dp (which holds crs_ram, crs_arith).
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | req_valid/req_stall, modulus, remainder, | in
//            | last                                     |
//   response | rsp_valid/rsp_stall, solution, status    | out
//
// A pair without last is stored and the request side stays open for the
// next pair. A pair marked last starts the solve, which runs divides and
// multiplies in turn on one shared unit. For n pairs that is n multiplies
// for the product, one divide per Euclid step of each of the n*(n-1)/2
// coprime checks, and per pair four divides, two multiplies and one
// divide plus one multiply per inverse step. The request side stalls for
// the whole solve and while the result waits; reset clears the pair count
// and state but leaves the pair store untouched, since unwritten entries
// are never read.
`default_nettype none

module chinese_remainder_solver #(
   parameter int unsigned MAX_PAIRS    = crs_pkg::MAX_PAIRS_DEF,
   parameter int unsigned MODULUS_BITS = crs_pkg::MODULUS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [crs_pkg::FIELD_W-1:0]   req_modulus,
   input  logic [crs_pkg::FIELD_W-1:0]   req_remainder,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [crs_pkg::WORD_W-1:0]    rsp_solution,
   output logic [crs_pkg::STATUS_W-1:0]  rsp_status
);
   import crs_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequence the solve
   crs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   // hold pairs, working registers and the shared divide/multiply unit
   crs_dp #(
      .MAX_PAIRS    (MAX_PAIRS),
      .MODULUS_BITS (MODULUS_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_modulus   (req_modulus),
      .req_remainder (req_remainder),
      .rsp_solution  (rsp_solution),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

/* hdl/crs_chk.sv */
// Port-level checks for the Chinese remainder solver, bound to the top.
// Depends on crs_pkg and chinese_remainder_solver.
`default_nettype none

module crs_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [crs_pkg::FIELD_W-1:0]   req_modulus,
   input logic [crs_pkg::FIELD_W-1:0]   req_remainder,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [crs_pkg::WORD_W-1:0]    rsp_solution,
   input logic [crs_pkg::STATUS_W-1:0]  rsp_status
);
   import crs_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_solution))
      else $error("result dropped or changed while stalled");

   // close the request side while a result waits
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request open while result pending");

   // start the solve after a last item
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall && !rsp_valid)
      else $error("no solve after last item");

   // drop the solution on any error status
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_solution == '0)
      else $error("nonzero solution with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_OVERFLOW)
                    || (rsp_status == STATUS_COMMON))
      else $error("undefined status code");

endmodule

bind chinese_remainder_solver crs_chk u_crs_chk (.*);

`default_nettype wire

/* test/crs_checker.sv */
// Checker for the Chinese remainder solver: watches both channels and
// predicts each result. Depends on crs_pkg for the status codes and sizes.
`default_nettype none

module crs_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [crs_pkg::FIELD_W-1:0]  req_modulus,
   input  logic [crs_pkg::FIELD_W-1:0]  req_remainder,
   input  logic                         req_last,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [crs_pkg::WORD_W-1:0]   rsp_solution,
   input  logic [crs_pkg::STATUS_W-1:0] rsp_status,
   output int                           errors,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import crs_pkg::*;

   localparam int unsigned PAIR_LIMIT = MAX_PAIRS_DEF;

   typedef struct packed {
      logic [WORD_W-1:0] solution;
      status_type        status;
   } answer_type;

   answer_type         answers[$];
   logic [63:0]        moduli[PAIR_LIMIT];
   logic [63:0]        remainders[PAIR_LIMIT];
   int unsigned        held;

   function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic logic [63:0] inverse_of(input logic [63:0] a, input logic [63:0] m);
      logic [63:0] base, q, t;
      longint      prev, cur, s;
      base = m;
      prev = 0;
      cur  = 1;
      if (m == 1) return 0;
      while (a > 1 && m != 0) begin
         q    = a / m;
         t    = m;
         m    = a % m;
         a    = t;
         s    = prev;
         prev = cur - longint'(q) * prev;
         cur  = s;
      end
      if (cur < 0) cur += longint'(base);
      return 64'(cur);
   endfunction

   function automatic answer_type solve_set();
      answer_type  ans;
      logic [63:0] product, m, c, iv, t, sum, s;
      ans.solution = '0;
      ans.status   = STATUS_OK;
      for (int i = 0; i < held; i++)
         if (moduli[i] == 0) begin
            ans.status = STATUS_COMMON;
            return ans;
         end
      product = 1;
      for (int i = 0; i < held; i++) begin
         if (product > 64'hFFFF_FFFF_FFFF_FFFF / moduli[i]) begin
            ans.status = STATUS_OVERFLOW;
            return ans;
         end
         product = product * moduli[i];
      end
      for (int i = 0; i < held; i++)
         for (int j = i + 1; j < held; j++)
            if (gcd64(moduli[i], moduli[j]) != 1) begin
               ans.status = STATUS_COMMON;
               return ans;
            end
      sum = 0;
      for (int i = 0; i < held; i++) begin
         m  = moduli[i];
         c  = product / m;
         iv = inverse_of(c % m, m);
         t  = ((remainders[i] % m) * iv) % m;
         s  = sum + t * c;
         if (s < sum || s >= product) s = s - product;
         sum = s;
      end
      ans.solution = sum;
      return ans;
   endfunction

   assign outstanding = answers.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         held   = 0;
         errors = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (held < PAIR_LIMIT) begin
               moduli[held]     = 64'(req_modulus);
               remainders[held] = 64'(req_remainder);
               held             = held + 1;
            end
            if (req_last) begin
               answers = {answers, solve_set()};
               held = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               $display("%0t: unexpected result solution=%h status=%0d",
                        $time, rsp_solution, rsp_status);
               errors = errors + 1;
            end else begin
               want = answers.pop_front();
               if (rsp_solution !== want.solution) begin
                  $display("%0t: solution expected %h actual %h",
                           $time, want.solution, rsp_solution);
                  errors = errors + 1;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors = errors + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* test/tb_chinese_remainder_solver.sv */
// Testbench top for the Chinese remainder solver: drives pair sets, stalls
// the result side and reports the verdict. Depends on crs_pkg, crs_checker.
`default_nettype none

module tb_chinese_remainder_solver;
   timeunit 1ns;
   timeprecision 1ps;
   import crs_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FIELD_W-1:0]  req_modulus = '0;
   logic [FIELD_W-1:0]  req_remainder = '0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [WORD_W-1:0]   rsp_solution;
   logic [STATUS_W-1:0] rsp_status;
   int                  errors;
   int                  outstanding;

   // idle percentages of the sender and the receiver, switched per phase
   int unsigned         send_idle = 17;
   int unsigned         recv_stall = 50;
   int unsigned         sent = 0;

   chinese_remainder_solver dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_modulus(req_modulus), .req_remainder(req_remainder), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_solution(rsp_solution), .rsp_status(rsp_status)
   );

   crs_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_modulus(req_modulus), .req_remainder(req_remainder), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_solution(rsp_solution), .rsp_status(rsp_status),
      .errors(errors), .outstanding(outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // stall the result side at random; the draw is made every edge
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   // Offer one pair, idling at random first, and hold it until accepted.
   // Valid stays high between back-to-back items so no edge toggles it twice.
   task automatic send_pair(input logic [31:0] m, input logic [31:0] r, input logic l);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_modulus   <= m;
      req_remainder <= r;
      req_last      <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // Send one random set of n pairs. Modulus widths are chosen so that the
   // product usually fits in 64 bits; a few sets use full widths to overflow.
   task automatic send_random_set(input int unsigned n);
      int unsigned w;
      logic [31:0] m;
      bit          wide;
      wide = ($urandom_range(99) < 6);
      for (int i = 0; i < n; i++) begin
         if (wide) w = 32;
         else w = $urandom_range((64 / n > 32) ? 32 : 64 / n, 1);
         m = $urandom() & (32'hFFFF_FFFF >> (32 - w));
         // a zero draw, and one draw in a hundred, turns into 0 or 1 with equal odds
         if (m == 0 || $urandom_range(99) == 0) m = ($urandom_range(99) < 50) ? 32'd0 : 32'd1;
         send_pair(m, $urandom(), i == n - 1);
      end
   endtask

   function automatic int unsigned pick_size();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(3, 1);
      if (roll < 94) return $urandom_range(5, 4);
      return $urandom_range(9, 6);
   endfunction

   initial begin
      int unsigned small_primes[8] = '{3, 5, 7, 11, 13, 17, 19, 23};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single pairs at the field extremes, one with its remainder above its modulus
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_pair(32'd1, 32'hFFFF_FFFF, 1'b1);
      send_pair(32'd7, 32'd0, 1'b1);
      // zero modulus
      send_pair(32'd5, 32'd3, 1'b0);
      send_pair(32'd0, 32'd1, 1'b1);
      // product overflow across three wide moduli
      send_pair(32'hFFFF_FFFB, 32'd2, 1'b0);
      send_pair(32'hFFFF_FFF1, 32'd9, 1'b0);
      send_pair(32'hFFFF_FFEF, 32'd4, 1'b1);
      // common factor
      send_pair(32'd6, 32'd1, 1'b0);
      send_pair(32'd4, 32'd3, 1'b1);
      // two wide coprime moduli whose product just fits
      send_pair(32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
      send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
      // a full set plus one extra: the extra pair, marked last, is dropped
      for (int i = 0; i < 8; i++) send_pair(small_primes[i], 100 + i, 1'b0);
      send_pair(32'd29, 32'd5, 1'b1);

      // three idling phases over the random part
      for (int phase = 0; phase < 3; phase++) begin
         send_idle  = (phase == 0) ? 17 : (phase == 1) ? 50 : 0;
         recv_stall = (phase == 0) ? 50 : (phase == 1) ? 17 : 0;
         while (sent < 25 + (phase + 1) * 510) send_random_set(pick_size());
      end
      req_valid <= 1'b0;

      // let the checker log the last item before waiting on it
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard limit on the run
   initial begin
      #1_000_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
